@@ hdl/sdr_pkg.sv @@
package sdr_pkg;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_REQUEST = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   localparam logic [1:0] PH_WAIT  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_DOWN  = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   localparam logic [1:0] REG_RETRY  = 2'd0;
   localparam logic [1:0] REG_SETTLE = 2'd1;
   localparam logic [1:0] REG_POLL   = 2'd2;

   localparam logic [15:0] RETRY_RESET  = 16'd100;
   localparam logic [15:0] SETTLE_RESET = 16'd10;
   localparam logic [15:0] POLL_RESET   = 16'd100;

   typedef struct packed {
      logic [15:0] retry_ticks;
      logic [15:0] settle_ticks;
      logic [15:0] poll_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [13:0] write_address;
      logic [7:0]  write_data;
      logic [7:0]  request_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       clearing;
      logic [1:0] phase;
   } stat_type;

endpackage

@@ hdl/sdr_ram.sv @@
module sdr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sdr_ctrl.sv @@
module sdr_ctrl
   import sdr_pkg::*;
#(
   parameter int MAX_SLICES = 64
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_stall,
   input  logic                                             req_mode,
   input  logic [7:0]                                       req_slice_index,
   input  logic [7:0]                                       req_slice_total,
   input  logic [7:0]                                       req_slice_size,
   input  logic [7:0]                                       req_byte_offset,
   input  logic [7:0]                                       req_data_byte,
   input  logic                                             req_last_byte,
   input  logic                                             req_link_stable,
   input  cfg_type                                          cfg,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output rsp_type                                          rsp,
   output stat_type                                         stat,
   output logic                                             map_wr_en,
   output logic [(MAX_SLICES > 1 ? $clog2(MAX_SLICES) : 1)-1:0] map_wr_addr,
   output logic                                             map_wr_data,
   output logic                                             map_rd_en,
   output logic [(MAX_SLICES > 1 ? $clog2(MAX_SLICES) : 1)-1:0] map_rd_addr,
   input  logic                                             map_rd_data
);

   localparam int AW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam logic [7:0] MaxSlc  = 8'(MAX_SLICES);
   localparam logic [7:0] MaxLast = 8'(MAX_SLICES - 1);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_LOOK     = 3'd2;
   localparam logic [2:0] ST_SCAN_RD  = 3'd3;
   localparam logic [2:0] ST_SCAN_CHK = 3'd4;
   localparam logic [2:0] ST_SCAN_END = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [6:0]  stored_ff, stored_in;
   logic [15:0] countdown_ff, countdown_in;
   logic        armed_ff, armed_in;
   logic        ok_ff, ok_in;
   logic        mid_ff, mid_in;
   logic [7:0]  scan_ff, scan_in;
   logic [7:0]  limit_ff, limit_in;
   logic [7:0]  pend_ff, pend_in;
   logic        have_pend_ff, have_pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [7:0]  h_idx_ff, h_idx_in;
   logic [7:0]  h_total_ff, h_total_in;
   logic [7:0]  h_size_ff, h_size_in;
   logic [7:0]  h_off_ff, h_off_in;
   logic [7:0]  h_data_ff, h_data_in;
   logic        h_last_ff, h_last_in;

   logic        out_free;
   logic        accept;
   logic [7:0]  mul_a, mul_b, off_sel;
   logic [15:0] addr_full;
   logic [7:0]  lim_calc;
   logic [7:0]  scan_nx;
   logic        hdr;
   logic        ok_new;
   logic        emit;
   rsp_type     emit_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && out_free);
   assign accept    = req_valid && !req_stall;

   // shared address multiplier: held fields while deciding a first byte
   assign mul_a     = (state_ff == ST_LOOK) ? h_size_ff : req_slice_size;
   assign mul_b     = (state_ff == ST_LOOK) ? h_idx_ff : req_slice_index;
   assign off_sel   = (state_ff == ST_LOOK) ? h_off_ff : req_byte_offset;
   assign addr_full = (16'(mul_a) * 16'(mul_b)) + 16'(off_sel);

   assign lim_calc  = ({1'b0, stored_ff} < MaxSlc) ? {1'b0, stored_ff} : MaxSlc;
   assign scan_nx   = scan_ff + 8'd1;
   assign hdr       = (h_idx_ff < h_total_ff) && (h_total_ff <= MaxSlc);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      stored_in    = stored_ff;
      countdown_in = countdown_ff;
      armed_in     = armed_ff;
      ok_in        = ok_ff;
      mid_in       = mid_ff;
      scan_in      = scan_ff;
      limit_in     = limit_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      h_idx_in     = h_idx_ff;
      h_total_in   = h_total_ff;
      h_size_in    = h_size_ff;
      h_off_in     = h_off_ff;
      h_data_in    = h_data_ff;
      h_last_in    = h_last_ff;
      ok_new       = 1'b0;
      emit         = 1'b0;
      emit_rsp     = '0;
      map_wr_en    = 1'b0;
      map_wr_addr  = scan_ff[AW-1:0];
      map_wr_data  = 1'b0;
      map_rd_en    = 1'b0;
      map_rd_addr  = scan_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            map_wr_en = 1'b1;
            if (scan_ff == MaxLast) begin
               scan_in  = 8'd0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_nx;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  if (!armed_ff || phase_ff == PH_DONE) begin
                     armed_in = 1'b0;
                  end else if (countdown_ff > 16'd1) begin
                     countdown_in = countdown_ff - 16'd1;
                  end else if (phase_ff == PH_WAIT && !req_link_stable) begin
                     countdown_in = cfg.poll_ticks;
                  end else if (phase_ff == PH_WAIT || phase_ff == PH_START) begin
                     phase_in      = PH_START;
                     countdown_in  = cfg.retry_ticks;
                     emit          = 1'b1;
                     emit_rsp.kind = KIND_REQUEST;
                     emit_rsp.last = 1'b1;
                  end else begin
                     limit_in     = lim_calc;
                     scan_in      = 8'd0;
                     have_pend_in = 1'b0;
                     state_in     = (lim_calc == 8'd0) ? ST_SCAN_END : ST_SCAN_RD;
                  end
               end else if (mid_ff) begin
                  mid_in = !req_last_byte;
                  if (ok_ff && req_byte_offset < req_slice_size) begin
                     emit                   = 1'b1;
                     emit_rsp.kind          = KIND_WRITE;
                     emit_rsp.write_address = addr_full[13:0];
                     emit_rsp.write_data    = req_data_byte;
                     emit_rsp.last          = 1'b1;
                  end
               end else begin
                  h_idx_in    = req_slice_index;
                  h_total_in  = req_slice_total;
                  h_size_in   = req_slice_size;
                  h_off_in    = req_byte_offset;
                  h_data_in   = req_data_byte;
                  h_last_in   = req_last_byte;
                  map_rd_en   = 1'b1;
                  map_rd_addr = req_slice_index[AW-1:0];
                  state_in    = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               map_wr_addr = h_idx_ff[AW-1:0];
               map_wr_data = 1'b1;
               if (phase_ff == PH_START && hdr) begin
                  map_wr_en    = 1'b1;
                  stored_in    = h_total_ff[6:0];
                  phase_in     = PH_DOWN;
                  countdown_in = 16'd0;
                  armed_in     = 1'b1;
                  ok_new       = 1'b1;
               end else if (phase_ff == PH_DOWN && hdr && h_idx_ff < {1'b0, stored_ff}
                            && !map_rd_data) begin
                  map_wr_en    = 1'b1;
                  countdown_in = cfg.settle_ticks;
                  armed_in     = 1'b1;
                  ok_new       = 1'b1;
               end
               ok_in  = ok_new;
               mid_in = !h_last_ff;
               if (ok_new && h_off_ff < h_size_ff) begin
                  emit                   = 1'b1;
                  emit_rsp.kind          = KIND_WRITE;
                  emit_rsp.write_address = addr_full[13:0];
                  emit_rsp.write_data    = h_data_ff;
                  emit_rsp.last          = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            map_rd_en = 1'b1;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (out_free) begin
               // a missing slice is held back until it is known whether it is the final one
               if (!map_rd_data) begin
                  if (have_pend_ff) begin
                     emit                   = 1'b1;
                     emit_rsp.kind          = KIND_REQUEST;
                     emit_rsp.request_index = pend_ff;
                  end
                  pend_in      = scan_ff;
                  have_pend_in = 1'b1;
               end
               scan_in  = scan_nx;
               state_in = (scan_nx == limit_ff) ? ST_SCAN_END : ST_SCAN_RD;
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_rsp.last = 1'b1;
               if (have_pend_ff) begin
                  emit_rsp.kind          = KIND_REQUEST;
                  emit_rsp.request_index = pend_ff;
                  countdown_in           = cfg.retry_ticks;
               end else begin
                  emit_rsp.kind = KIND_DONE;
                  phase_in      = PH_DONE;
                  armed_in      = 1'b0;
                  countdown_in  = 16'd0;
               end
               scan_in  = 8'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_in       = emit ? emit_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_WAIT;
         stored_ff    <= 7'd0;
         countdown_ff <= 16'd0;
         armed_ff     <= 1'b1;
         ok_ff        <= 1'b0;
         mid_ff       <= 1'b0;
         scan_ff      <= 8'd0;
         limit_ff     <= 8'd0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         stored_ff    <= stored_in;
         countdown_ff <= countdown_in;
         armed_ff     <= armed_in;
         ok_ff        <= ok_in;
         mid_ff       <= mid_in;
         scan_ff      <= scan_in;
         limit_ff     <= limit_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
      h_idx_ff   <= h_idx_in;
      h_total_ff <= h_total_in;
      h_size_ff  <= h_size_in;
      h_off_ff   <= h_off_in;
      h_data_ff  <= h_data_in;
      h_last_ff  <= h_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;
   assign stat.clearing = (state_ff == ST_CLEAR);
   assign stat.phase    = phase_ff;

endmodule

@@ hdl/sliced_download_reassembler.sv @@
// Reassembles an image sent as numbered slices and asks again for missing ones. Each slice
// byte (req_mode low) of an accepted packet with byte_offset below slice_size comes out as a
// write at slice_size*slice_index+byte_offset; timer ticks (req_mode high) drive the request
// and retry logic. Later bytes of a packet need no map read; the first byte is held while the
// received-slice map in a single-port-read RAM is read before the packet is accepted or
// dropped. A tick that fires in the downloading phase walks that map, reading and then
// checking one entry at a time, over min(slice count, MAX_SLICES) entries. After reset the
// map is cleared entry by entry while req_stall stays high; csr writes are taken at any time.
// An item is only taken while the result register is free or being emptied.
module sliced_download_reassembler
   import sdr_pkg::*;
#(
   parameter int MAX_SLICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_slice_index,
   input  logic [7:0]  req_slice_total,
   input  logic [7:0]  req_slice_size,
   input  logic [7:0]  req_byte_offset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_link_stable,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [13:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic [7:0]  rsp_request_index,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int AW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

   logic [15:0] retry_ff, retry_in;
   logic [15:0] settle_ff, settle_in;
   logic [15:0] poll_ff, poll_in;
   cfg_type     cfg;
   rsp_type     rsp;
   stat_type    stat;

   logic          map_wr_en;
   logic [AW-1:0] map_wr_addr;
   logic          map_wr_data;
   logic          map_rd_en;
   logic [AW-1:0] map_rd_addr;
   logic          map_rd_data;

   always_comb begin
      retry_in  = retry_ff;
      settle_in = settle_ff;
      poll_in   = poll_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_RETRY:  retry_in  = csr_write_data;
            REG_SETTLE: settle_in = csr_write_data;
            REG_POLL:   poll_in   = csr_write_data;
            default:    retry_in  = retry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff  <= RETRY_RESET;
         settle_ff <= SETTLE_RESET;
         poll_ff   <= POLL_RESET;
      end else begin
         retry_ff  <= retry_in;
         settle_ff <= settle_in;
         poll_ff   <= poll_in;
      end
   end

   assign cfg.retry_ticks  = retry_ff;
   assign cfg.settle_ticks = settle_ff;
   assign cfg.poll_ticks   = poll_ff;

   sdr_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SLICES)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   sdr_ctrl #(
      .MAX_SLICES (MAX_SLICES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_slice_index (req_slice_index),
      .req_slice_total (req_slice_total),
      .req_slice_size  (req_slice_size),
      .req_byte_offset (req_byte_offset),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .req_link_stable (req_link_stable),
      .cfg             (cfg),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp             (rsp),
      .stat            (stat),
      .map_wr_en       (map_wr_en),
      .map_wr_addr     (map_wr_addr),
      .map_wr_data     (map_wr_data),
      .map_rd_en       (map_rd_en),
      .map_rd_addr     (map_rd_addr),
      .map_rd_data     (map_rd_data)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_write_address = rsp.write_address;
   assign rsp_write_data    = rsp.write_data;
   assign rsp_request_index = rsp.request_index;
   assign rsp_last          = rsp.last;

`ifndef ASSERT_OFF
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> (req_stall && !rsp_valid))
      else $error("item taken or result shown during map clear");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_WRITE || rsp_kind == KIND_REQUEST
                     || rsp_kind == KIND_DONE))
      else $error("result with undefined kind");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      stat.phase == PH_DONE |=> stat.phase == PH_DONE)
      else $error("left finished phase");

   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_WRITE) |-> (rsp_request_index == 8'd0 && rsp_last))
      else $error("write result with request index or not last");
`endif

endmodule
